// ===== sv/fds_pkg.sv =====
// shared types and constants for the fat directory entry search unit
`default_nettype none

package fds_pkg;

  // entry layout
  localparam int          ENTRY_BYTES    = 32;
  localparam int          COUNT_REACH    = 512;
  localparam logic [7:0]  END_MARK       = 8'h00;
  localparam logic [7:0]  DELETED_MARK   = 8'hE5;
  localparam logic [7:0]  LONG_NAME_BITS = 8'h0F;
  localparam logic [4:0]  NAME_BYTES     = 5'd11;
  localparam logic [4:0]  ATTR_POS       = 5'h0B;
  localparam logic [4:0]  CLUSTER_POS    = 5'h1A;
  localparam logic [4:0]  SIZE_POS       = 5'h1C;
  localparam logic [4:0]  LAST_POS       = 5'h1F;

  // configuration defaults
  localparam int          DEFAULT_MAX_SECTOR_BYTES = 512;
  localparam logic [9:0]  SECT_BYTES_RESET         = 10'd512;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_NAME_HEAD  = 2'd0,
    CFG_NAME_TAIL  = 2'd1,
    CFG_SECT_BYTES = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [63:0] name_head;
    logic [23:0] name_tail;
    logic [9:0]  sect_bytes;
  } cfg_regs_t;

  typedef struct packed {
    logic [7:0]  dir_byte;
    logic [31:0] sector_lba;
    logic        search_start;
    logic        dir_end;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [8:0]  entry_offset;
    logic [31:0] entry_lba;
    logic [15:0] start_cluster;
    logic [31:0] file_size;
    logic [7:0]  attributes;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/fds_scan.sv =====
// entry scanner: byte counter, name compare, field capture and result decision
`default_nettype none

module fds_scan #(
  parameter int MAX_SECTOR_BYTES = fds_pkg::DEFAULT_MAX_SECTOR_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fds_pkg::cfg_regs_t cfg,
  input  wire fds_pkg::in_item_t  item,
  input  wire logic              item_valid,
  input  wire logic              take,
  output logic                   res_valid,
  output fds_pkg::out_item_t     res
);
  import fds_pkg::*;

  // largest usable sector, a multiple of the entry size within counter reach
  localparam int LimRound = MAX_SECTOR_BYTES - (MAX_SECTOR_BYTES % ENTRY_BYTES);
  localparam int LimCap   = (LimRound > COUNT_REACH) ? COUNT_REACH : LimRound;
  localparam int LimFinal = (LimCap < ENTRY_BYTES) ? ENTRY_BYTES : LimCap;
  localparam logic [9:0] EffLim = 10'(LimFinal);

  logic [8:0]  cnt_r, cnt_nxt;
  logic        match_r, match_nxt;
  logic        skip_r, skip_nxt;
  logic [15:0] cluster_r, cluster_nxt;
  logic [31:0] size_r, size_nxt;
  logic [7:0]  attr_r, attr_nxt;
  logic        fin_r, fin_nxt;

  logic [9:0]  eff;
  logic [9:0]  size_round;
  logic [87:0] name_bits;
  logic [3:0]  name_idx;
  logic [7:0]  want;
  logic [8:0]  cnt;
  logic [4:0]  pos;
  logic        fin;
  logic        end_mark;
  logic        hit;
  logic        m_cur, s_cur;
  logic [9:0]  cnt_inc;

  // effective sector size from the configured value
  always_comb begin
    size_round = {cfg.sect_bytes[9:5], 5'b00000};
    if (cfg.sect_bytes[9:5] == 5'd0) begin
      eff = 10'(ENTRY_BYTES);
    end else if (size_round > EffLim) begin
      eff = EffLim;
    end else begin
      eff = size_round;
    end
  end

  // wanted name byte at this position
  assign name_bits = {cfg.name_tail, cfg.name_head};
  assign cnt       = item.search_start ? 9'd0 : cnt_r;
  assign pos       = cnt[4:0];
  assign name_idx  = (pos < NAME_BYTES) ? pos[3:0] : 4'd0;
  assign want      = name_bits[{name_idx, 3'b000} +: 8];
  assign fin       = item.search_start ? 1'b0 : fin_r;
  assign cnt_inc   = {1'b0, cnt} + 10'd1;

  // per-byte state update and result decision
  always_comb begin
    m_cur       = item.search_start ? 1'b1 : match_r;
    s_cur       = item.search_start ? 1'b0 : skip_r;
    cluster_nxt = item.search_start ? 16'd0 : cluster_r;
    size_nxt    = item.search_start ? 32'd0 : size_r;
    attr_nxt    = item.search_start ? 8'd0 : attr_r;
    end_mark    = 1'b0;

    if (pos == 5'd0) begin
      m_cur    = 1'b1;
      s_cur    = 1'b0;
      end_mark = (item.dir_byte == END_MARK);
      if (item.dir_byte == DELETED_MARK) begin
        s_cur = 1'b1;
      end
    end
    if (pos < NAME_BYTES && item.dir_byte != want) begin
      m_cur = 1'b0;
    end
    if (pos == ATTR_POS) begin
      attr_nxt = item.dir_byte;
      if ((item.dir_byte & LONG_NAME_BITS) == LONG_NAME_BITS) begin
        s_cur = 1'b1;
      end
    end
    if (pos == CLUSTER_POS) begin
      cluster_nxt[7:0] = item.dir_byte;
    end
    if (pos == CLUSTER_POS + 5'd1) begin
      cluster_nxt[15:8] = item.dir_byte;
    end
    if (pos >= SIZE_POS) begin
      case (pos[1:0])
        2'd0:    size_nxt[7:0]   = item.dir_byte;
        2'd1:    size_nxt[15:8]  = item.dir_byte;
        2'd2:    size_nxt[23:16] = item.dir_byte;
        default: size_nxt[31:24] = item.dir_byte;
      endcase
    end

    match_nxt = m_cur;
    skip_nxt  = s_cur;
    hit       = (pos == LAST_POS) && m_cur && !s_cur;

    if (end_mark) begin
      cnt_nxt = cnt;
    end else if (cnt_inc >= eff) begin
      cnt_nxt = 9'd0;
    end else begin
      cnt_nxt = cnt_inc[8:0];
    end
    fin_nxt = end_mark || hit || item.dir_end;

    res_valid = item_valid && !fin && (end_mark || hit || item.dir_end);

    res               = '0;
    res.found         = hit && !end_mark;
    if (hit && !end_mark) begin
      res.entry_offset  = {cnt[8:5], 5'b00000};
      res.entry_lba     = item.sector_lba;
      res.start_cluster = cluster_nxt;
      res.file_size     = size_nxt;
      res.attributes    = attr_nxt;
    end
  end

  // search state, updated when a transaction leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= 9'd0;
      match_r   <= 1'b1;
      skip_r    <= 1'b0;
      cluster_r <= 16'd0;
      size_r    <= 32'd0;
      attr_r    <= 8'd0;
      fin_r     <= 1'b1;
    end else if (take && !fin) begin
      cnt_r     <= cnt_nxt;
      match_r   <= match_nxt;
      skip_r    <= skip_nxt;
      cluster_r <= cluster_nxt;
      size_r    <= size_nxt;
      attr_r    <= attr_nxt;
      fin_r     <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/fat_dir_entry_search_unit.sv =====
// top level: configuration registers, input register, scanner and result register
//
// Usage: the input channel (in_valid, in_stall, in_data) takes one directory
// byte per transaction with its sector address and search start / directory
// end flags. The result channel (out_valid, out_stall, out_data) gives at most
// one transaction per search: found with offset, sector, cluster, size and
// attributes, or not found with all other fields zero. The configuration port
// (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready; write it only
// while no search is in flight.
// Timing: a byte that is taken sits in the input register, and its result is
// loaded from there into the result register, which drives out_valid and
// out_data until the result leaves on the result channel.
// One byte is taken every cycle; the input register frees each cycle unless
// it holds a result-causing byte while the result register is full and stalled.
// Reset: the unit is idle until a byte with search_start; name registers read
// zero and the sector size reads 512. A stall on the result side holds the
// result register and, once a further result is pending, stalls the input.
`default_nettype none

module fat_dir_entry_search_unit #(
  parameter int MAX_SECTOR_BYTES = fds_pkg::DEFAULT_MAX_SECTOR_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire fds_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output fds_pkg::out_item_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [63:0]       cfg_data
);
  import fds_pkg::*;

  cfg_regs_t cfg_r;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t out_data_r;
  logic      out_valid_r;

  logic      res_valid;
  out_item_t res;
  logic      out_free;
  logic      take;

  assign cfg_ready = 1'b1;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.name_head  <= 64'd0;
      cfg_r.name_tail  <= 24'd0;
      cfg_r.sect_bytes <= SECT_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NAME_HEAD:  cfg_r.name_head  <= cfg_data;
        CFG_NAME_TAIL:  cfg_r.name_tail  <= cfg_data[23:0];
        CFG_SECT_BYTES: cfg_r.sect_bytes <= cfg_data[9:0];
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  // flow control between the two registers
  assign out_free = !out_valid_r || !out_stall;
  assign take     = in_valid_r && (!res_valid || out_free);
  assign in_stall = in_valid_r && !take;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (take) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  fds_scan #(
    .MAX_SECTOR_BYTES(MAX_SECTOR_BYTES)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (in_item_r),
    .item_valid (in_valid_r),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a held result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(take && res_valid))
    else $error("result register overwritten while stalled");

  // the scanner only advances on a held input transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    take |-> in_valid_r)
    else $error("scanner advanced without an input transaction");

  // a not-found result carries zero fields
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |->
      (out_data_r.entry_lba == 32'd0 && out_data_r.file_size == 32'd0 &&
       out_data_r.entry_offset == 9'd0))
    else $error("not-found result with non-zero fields");

  // a delivered result leaves the output register free or refilled
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !(take && res_valid)) |=> !out_valid_r)
    else $error("result delivered twice");

endmodule

`default_nettype wire

// ===== dv/dir_lookup_checker.sv =====
// checker for the directory entry search unit: predicts every lookup result and compares
`timescale 1ns / 1ps

module dir_lookup_checker #(
  parameter int MAX_SECTOR_BYTES = fds_pkg::DEFAULT_MAX_SECTOR_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  fds_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  fds_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 bad_lookups,
  output int                 lookups_open,
  output int                 lookups_done
);
  import fds_pkg::*;

  // register copies
  logic [63:0] name_head_r;
  logic [23:0] name_tail_r;
  logic [9:0]  sect_bytes_r;

  // scan state
  logic [8:0]  byte_cnt;
  bit          name_ok;
  bit          skip_entry;
  bit          search_idle;
  logic [15:0] cluster_r;
  logic [31:0] file_size_r;
  logic [7:0]  attr_r;

  out_item_t   lookup_results_q [$];
  int          err_total;
  int          done_total;

  // bytes per sector after rounding and clamping
  function automatic int sector_bytes();
    int lim;
    int s;
    lim = MAX_SECTOR_BYTES - MAX_SECTOR_BYTES % ENTRY_BYTES;
    s   = int'(sect_bytes_r) - int'(sect_bytes_r) % ENTRY_BYTES;
    if (lim > COUNT_REACH) lim = COUNT_REACH;
    if (lim < ENTRY_BYTES) lim = ENTRY_BYTES;
    if (s < ENTRY_BYTES) s = ENTRY_BYTES;
    if (s > lim) s = lim;
    return s;
  endfunction

  function automatic logic [7:0] name_byte(input logic [4:0] pos);
    if (pos < 8) return name_head_r[8*pos +: 8];
    return name_tail_r[8*(pos-8) +: 8];
  endfunction

  function automatic void clear_lookup();
    byte_cnt    = '0;
    name_ok     = 1'b1;
    skip_entry  = 1'b0;
    cluster_r   = '0;
    file_size_r = '0;
    attr_r      = '0;
  endfunction

  function automatic string describe(input out_item_t r);
    return $sformatf("found=%0d off=%0d lba=%h cluster=%h size=%h attr=%h",
                     r.found, r.entry_offset, r.entry_lba, r.start_cluster,
                     r.file_size, r.attributes);
  endfunction

  // one directory byte through the scan; returns 1 when it ends a lookup
  function automatic bit scan_dir_byte(input in_item_t item, output out_item_t hit);
    logic [8:0] cnt;
    logic [4:0] pos;
    logic [7:0] b;
    int         sh;
    hit = '0;
    if (item.search_start) begin
      clear_lookup();
      search_idle = 1'b0;
    end
    if (search_idle) return 1'b0;
    b   = item.dir_byte;
    cnt = byte_cnt;
    pos = cnt[4:0];
    // entry head: end of directory or deleted entry
    if (pos == 0) begin
      name_ok    = 1'b1;
      skip_entry = 1'b0;
      if (b == END_MARK) begin
        search_idle = 1'b1;
        return 1'b1;
      end
      if (b == DELETED_MARK) skip_entry = 1'b1;
    end
    if (pos < NAME_BYTES && b != name_byte(pos)) name_ok = 1'b0;
    if (pos == ATTR_POS) begin
      attr_r = b;
      if ((b & LONG_NAME_BITS) == LONG_NAME_BITS) skip_entry = 1'b1;
    end
    if (pos == CLUSTER_POS) cluster_r[7:0] = b;
    if (pos == CLUSTER_POS + 5'd1) cluster_r[15:8] = b;
    if (pos >= SIZE_POS) begin
      sh = 8 * (int'(pos) - int'(SIZE_POS));
      file_size_r[sh +: 8] = b;
    end
    byte_cnt = (int'(cnt) + 1 >= sector_bytes()) ? '0 : cnt + 9'd1;
    // match wins over directory end on the same byte
    if (pos == LAST_POS && name_ok && !skip_entry) begin
      search_idle       = 1'b1;
      hit.found         = 1'b1;
      hit.entry_offset  = {cnt[8:5], 5'd0};
      hit.entry_lba     = item.sector_lba;
      hit.start_cluster = cluster_r;
      hit.file_size     = file_size_r;
      hit.attributes    = attr_r;
      return 1'b1;
    end
    if (item.dir_end) begin
      search_idle = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // watch all three channels
  always @(posedge clk) begin : track
    out_item_t hit;
    out_item_t want;
    if (!rst_n) begin
      name_head_r  = '0;
      name_tail_r  = '0;
      sect_bytes_r = SECT_BYTES_RESET;
      clear_lookup();
      search_idle  = 1'b1;
      lookup_results_q.delete();
      err_total    = 0;
      done_total   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NAME_HEAD:  name_head_r  = cfg_data;
          CFG_NAME_TAIL:  name_tail_r  = cfg_data[23:0];
          CFG_SECT_BYTES: sect_bytes_r = cfg_data[9:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (scan_dir_byte(in_data, hit)) lookup_results_q.push_back(hit);
      end
      // result transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        done_total++;
        if (lookup_results_q.size() == 0) begin
          if (err_total < 10)
            $display("%0t: result with no lookup waiting: %s", $time, describe(out_data));
          err_total++;
        end else begin
          want = lookup_results_q.pop_front();
          if (out_data.found !== want.found ||
              out_data.entry_offset !== want.entry_offset ||
              out_data.entry_lba !== want.entry_lba ||
              out_data.start_cluster !== want.start_cluster ||
              out_data.file_size !== want.file_size ||
              out_data.attributes !== want.attributes) begin
            if (err_total < 10)
              $display("%0t: mismatch, expected %s, got %s", $time, describe(want),
                       describe(out_data));
            err_total++;
          end
        end
      end
    end
    bad_lookups  <= err_total;
    lookups_open <= lookup_results_q.size();
    lookups_done <= done_total;
  end

endmodule

// ===== dv/fat_dir_entry_search_unit_test.sv =====
// testbench top for the directory entry search unit: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module fat_dir_entry_search_unit_test;
  import fds_pkg::*;

  localparam int ITEM_TARGET    = 700;
  localparam int RESULT_TARGET  = 40;
  localparam int PHASE_ITEMS    = 100;
  localparam int HOLD_OFF       = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef enum {ENT_MATCH, ENT_NEAR, ENT_DELETED, ENT_LONG_NAME, ENT_RANDOM} entry_kind_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data  = '0;

  int          bad_lookups;
  int          lookups_open;
  int          lookups_done;

  int          items_sent   = 0;
  int          idle_pct     = 6;
  bit          calm         = 1'b0;
  int          stall_left   = 0;
  int          quiet_cycles = 0;
  logic [7:0]  name_bytes [11];
  logic [7:0]  entry_buf [32];
  int          size_plan [9] = '{512, 32, 0, 1023, 96, 511, 33, 64, 160};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fat_dir_entry_search_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dir_lookup_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .bad_lookups  (bad_lookups),
    .lookups_open (lookups_open),
    .lookups_done (lookups_done)
  );

  // result side stalls in short bursts, none while calm
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 999) < 11) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic in_item_t make_item(input logic [7:0] b, input logic [31:0] lba,
                                         input bit start, input bit last);
    in_item_t item;
    item.dir_byte     = b;
    item.sector_lba   = lba;
    item.search_start = start;
    item.dir_end      = last;
    return item;
  endfunction

  // one input transaction, with an optional random gap first
  task automatic push_byte(input in_item_t item);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // hold the input until every lookup has reported, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lookups_open != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  // wanted name: printable, all ones, all zero, deleted lead, any bytes
  function automatic void load_name(input int mode);
    for (int i = 0; i < 11; i++) begin
      case (mode)
        0:       name_bytes[i] = (i >= 6 && i < 8) ? 8'h20 : 8'($urandom_range(8'h41, 8'h5A));
        1:       name_bytes[i] = 8'hFF;
        2:       name_bytes[i] = 8'h00;
        3:       name_bytes[i] = (i == 0) ? DELETED_MARK : 8'($urandom_range(8'h30, 8'h39));
        default: name_bytes[i] = 8'($urandom_range(0, 255));
      endcase
    end
  endfunction

  function automatic entry_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return ENT_MATCH;
    if (r < 35) return ENT_NEAR;
    if (r < 45) return ENT_DELETED;
    if (r < 55) return ENT_LONG_NAME;
    return ENT_RANDOM;
  endfunction

  // 32-byte directory entry of the given kind
  function automatic void fill_entry(input entry_kind_t kind);
    int k;
    for (int i = 0; i < 32; i++) entry_buf[i] = 8'($urandom_range(0, 255));
    if (kind != ENT_RANDOM)
      for (int i = 0; i < 11; i++) entry_buf[i] = name_bytes[i];
    case (kind)
      ENT_MATCH: begin
        if ((entry_buf[ATTR_POS] & LONG_NAME_BITS) == LONG_NAME_BITS)
          entry_buf[ATTR_POS][$urandom_range(0, 3)] = 1'b0;
      end
      ENT_NEAR: begin
        k = $urandom_range(0, 10);
        entry_buf[k] = entry_buf[k] ^ 8'($urandom_range(1, 255));
      end
      ENT_DELETED:   entry_buf[0] = DELETED_MARK;
      ENT_LONG_NAME: entry_buf[ATTR_POS] = entry_buf[ATTR_POS] | LONG_NAME_BITS;
      default: ;
    endcase
  endfunction

  // one directory search: entries, then an end marker, a directory end or nothing
  task automatic run_directory();
    int          n_ent;
    int          term;
    int          stop_at;
    logic [31:0] lba;
    bit          first;
    bit          long_dir;
    bit          closing;
    entry_kind_t kind;
    long_dir = ($urandom_range(0, 7) == 0);
    n_ent    = long_dir ? $urandom_range(5, 18) : $urandom_range(1, 3);
    term     = $urandom_range(0, 9);
    case ($urandom_range(0, 9))
      0:       lba = '0;
      1:       lba = '1;
      default: lba = $urandom;
    endcase
    first = 1'b1;
    for (int e = 0; e < n_ent; e++) begin
      closing = (e == n_ent - 1);
      kind    = pick_kind();
      // long directories push the match far into the sector
      if (long_dir && kind == ENT_MATCH && !closing) kind = ENT_NEAR;
      if (long_dir && closing && $urandom_range(0, 1)) kind = ENT_MATCH;
      fill_entry(kind);
      stop_at = 31;
      if (closing && term <= 2) begin
        entry_buf[0] = END_MARK;
        stop_at      = 0;
      end
      if (closing && (term == 7 || term == 8)) stop_at = $urandom_range(0, 31);
      for (int i = 0; i <= stop_at; i++) begin
        push_byte(make_item(entry_buf[i], lba, first,
                            closing && i == stop_at && term >= 2 && term <= 8));
        first = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) lba++;
    end
    // trailing bytes after the end marker are ignored
    if (term <= 2)
      repeat ($urandom_range(0, 3))
        push_byte(make_item(8'($urandom_range(0, 255)), $urandom, 1'b0,
                            1'($urandom_range(0, 1))));
  endtask

  // unstructured bytes with random flags
  task automatic push_noise();
    repeat ($urandom_range(5, 20))
      push_byte(make_item(8'($urandom_range(0, 255)), $urandom,
                          $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0));
  endtask

  initial begin
    int          phase;
    int          mode;
    int          sect;
    int          phase_start;
    logic [63:0] head;
    logic [23:0] tail;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle bytes, end markers, directory end, restart mid search
    push_byte(make_item(8'h00, 32'h0000_0000, 1'b0, 1'b0));
    push_byte(make_item(8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1));
    push_byte(make_item(END_MARK, 32'h0000_0100, 1'b1, 1'b0));
    push_byte(make_item(END_MARK, 32'h0000_0101, 1'b1, 1'b1));
    push_byte(make_item(8'h41, 32'h0000_0102, 1'b1, 1'b1));
    push_byte(make_item(8'h41, 32'h8000_0000, 1'b1, 1'b0));
    push_byte(make_item(8'h42, 32'h8000_0000, 1'b0, 1'b0));
    push_byte(make_item(8'h43, 32'h8000_0000, 1'b0, 1'b0));
    push_byte(make_item(END_MARK, 32'h8000_0001, 1'b1, 1'b0));
    push_byte(make_item(8'h20, 32'h0000_0001, 1'b0, 1'b0));
    push_byte(make_item(8'h20, 32'h0000_0001, 1'b0, 1'b1));
    push_byte(make_item(DELETED_MARK, 32'h7FFF_FFFF, 1'b1, 1'b0));
    push_byte(make_item(8'hFF, 32'h7FFF_FFFF, 1'b0, 1'b1));
    push_byte(make_item(8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0));
    push_byte(make_item(8'h00, 32'hFFFF_FFFF, 1'b0, 1'b1));

    // random phases, each with its own name and sector size
    phase = 0;
    while (items_sent < ITEM_TARGET || lookups_done < RESULT_TARGET) begin
      settle();
      calm     <= (phase == 3 || phase == 4);
      idle_pct = (phase == 3 || phase == 4) ? 0 : 6;
      if (phase < 5) mode = phase;
      else mode = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      load_name(mode);
      sect = (phase < 9) ? size_plan[phase] : $urandom_range(0, 1023);
      for (int i = 0; i < 8; i++) head[8*i +: 8] = name_bytes[i];
      for (int i = 0; i < 3; i++) tail[8*i +: 8] = name_bytes[8 + i];
      write_reg(CFG_NAME_HEAD, head);
      write_reg(CFG_NAME_TAIL, {40'd0, tail});
      write_reg(CFG_SECT_BYTES, {54'd0, sect[9:0]});
      cfg_valid <= 1'b0;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 11) == 0) push_noise();
        else run_directory();
      end
      // close any open search before the next register write
      push_byte(make_item(8'($urandom_range(0, 255)), $urandom, 1'b1, 1'b1));
      phase++;
    end

    // drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (lookups_open != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_lookups == 0 && lookups_open == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== fat_dir_entry_search_unit.f =====
sv/fds_pkg.sv
sv/fds_scan.sv
sv/fat_dir_entry_search_unit.sv
dv/dir_lookup_checker.sv
dv/fat_dir_entry_search_unit_test.sv
